// ===== design/germ_pkg.sv =====
// Shared constants, command codes and pipeline tag type of the row matcher.
`default_nettype none
package germ_pkg;

  // Parameter defaults
  localparam int MAX_ROWS_DEF    = 16;
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int TGT_W   = 17;
  localparam int CFG_W   = 5;
  localparam int Q_FRAC  = 16;

  localparam logic [TGT_W-1:0] Q_ONE = 17'h10000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHAIN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Flags that travel with each term through the score pipeline
  typedef struct packed {
    logic valid;
    logic self;   // term column equals candidate column
    logic first;  // first term of a candidate
    logic last;   // last term of a candidate
  } germ_tag_t;

endpackage
`default_nettype wire

// ===== design/greedy_empirical_row_matcher.sv =====
// Top level of the greedy empirical row matcher: configuration registers and core.
//
// A step word is taken in the idle state and passes through a visit read, the scoring
// of every candidate column against every column of the row by a single shared term
// unit, one term per cycle, fed from the count and target memories, a pipeline drain
// and a count read and write-back, which loads the output register; the next word can
// be taken once the block is back in idle. While the previous result still waits in the
// output register, the step holds in its write-back state. Load, start-state and
// ignored words are taken without leaving the idle state. A clear word, and reset
// itself, sweep the count and visit memories one entry per cycle, with in_stall high;
// configuration writes are taken meanwhile. A finished result waits in an output
// register while the next word is taken.
`default_nettype none
module greedy_empirical_row_matcher #(
  parameter int MAX_ROWS    = germ_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = germ_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = germ_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [germ_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [germ_pkg::CMD_W-1:0]  command,
  input  wire logic [germ_pkg::IDX_W-1:0]  row_index,
  input  wire logic [germ_pkg::IDX_W-1:0]  column_index,
  input  wire logic [germ_pkg::TGT_W-1:0]  target_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [germ_pkg::IDX_W-1:0]       chosen_column,
  output logic [germ_pkg::IDX_W-1:0]       row_used,
  output logic                             count_saturated
);
  import germ_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLUMNS);

  logic [CFG_W-1:0] rows_cfg, cols_cfg;
  logic [ROW_W:0]   nr;
  logic [COL_W:0]   nc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= CFG_RESET;
      cols_cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_data;
        REG_COLS: cols_cfg <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Effective row and column counts: zero acts as one, clamp at the maximum
  always_comb begin
    if (rows_cfg == '0) nr = (ROW_W+1)'(1);
    else if (32'(rows_cfg) > 32'(MAX_ROWS)) nr = (ROW_W+1)'(MAX_ROWS);
    else nr = (ROW_W+1)'(rows_cfg);
    if (cols_cfg == '0) nc = (COL_W+1)'(1);
    else if (32'(cols_cfg) > 32'(MAX_COLUMNS)) nc = (COL_W+1)'(MAX_COLUMNS);
    else nc = (COL_W+1)'(cols_cfg);
  end

  germ_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .COUNT_BITS (COUNT_BITS),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .nr             (nr),
    .nc             (nc),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .row_index      (row_index),
    .column_index   (column_index),
    .target_value   (target_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .chosen_column  (chosen_column),
    .row_used       (row_used),
    .count_saturated(count_saturated)
  );

endmodule
`default_nettype wire

// ===== design/germ_term_unit.sv =====
// Shared term unit: multiply, absolute difference and per-candidate accumulation.
`default_nettype none
module germ_term_unit #(
  parameter int COUNT_BITS = germ_pkg::COUNT_BITS_DEF,
  parameter int COL_W      = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire germ_pkg::germ_tag_t         tag,
  input  wire logic [COL_W-1:0]            col,
  input  wire logic [germ_pkg::TGT_W-1:0]  p,
  input  wire logic [COUNT_BITS-1:0]       n,
  input  wire logic [COUNT_BITS-1:0]       d,
  output logic                             sc_valid,
  output logic [COUNT_BITS+17+COL_W-1:0]   sc_score,
  output logic                             sc_elig,
  output logic [COL_W-1:0]                 sc_col
);
  import germ_pkg::*;

  localparam int TERM_W  = COUNT_BITS + 17;
  localparam int SCORE_W = TERM_W + COL_W;

  logic               a_valid, a_first, a_last, a_nz;
  logic [COL_W-1:0]   a_col;
  logic [TERM_W-1:0]  a_prod, a_nsh;
  logic [COUNT_BITS:0] nadj;

  logic [TERM_W-1:0]  term;
  logic [SCORE_W-1:0] acc, sum;
  logic               elig, elig_sum;

  assign nadj = {1'b0, n} + (COUNT_BITS+1)'(tag.self);

  // Stage A: product and scaled count
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= tag.valid;
    end
    a_first <= tag.first;
    a_last  <= tag.last;
    a_nz    <= tag.self && (p != '0);
    a_col   <= col;
    a_prod  <= TERM_W'(p) * TERM_W'(d);
    a_nsh   <= {nadj, {Q_FRAC{1'b0}}};
  end

  // Stage B: absolute difference and accumulate
  always_comb begin
    term     = (a_prod >= a_nsh) ? (a_prod - a_nsh) : (a_nsh - a_prod);
    sum      = (a_first ? '0 : acc) + SCORE_W'(term);
    elig_sum = (a_first ? 1'b0 : elig) | a_nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else begin
      sc_valid <= a_valid && a_last;
    end
    if (a_valid) begin
      acc  <= sum;
      elig <= elig_sum;
    end
    sc_score <= sum;
    sc_elig  <= elig_sum;
    sc_col   <= a_col;
  end

endmodule
`default_nettype wire

// ===== design/germ_seq.sv =====
// Sequencer with target, count and visit memories and the result register.
`default_nettype none
module germ_seq #(
  parameter int MAX_ROWS    = germ_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = germ_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = germ_pkg::COUNT_BITS_DEF,
  parameter int ROW_W       = $clog2(MAX_ROWS),
  parameter int COL_W       = $clog2(MAX_COLUMNS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ROW_W:0]              nr,
  input  wire logic [COL_W:0]              nc,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [germ_pkg::CMD_W-1:0]  command,
  input  wire logic [germ_pkg::IDX_W-1:0]  row_index,
  input  wire logic [germ_pkg::IDX_W-1:0]  column_index,
  input  wire logic [germ_pkg::TGT_W-1:0]  target_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [germ_pkg::IDX_W-1:0]       chosen_column,
  output logic [germ_pkg::IDX_W-1:0]       row_used,
  output logic                             count_saturated
);
  import germ_pkg::*;

  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int TERM_W  = COUNT_BITS + 17;
  localparam int SCORE_W = TERM_W + COL_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_VIS   = 7'b0000100,
    S_SCORE = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_CRD   = 7'b0100000,
    S_CWR   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [TGT_W-1:0]      tgt_mem [DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0] vis_mem [1 << ROW_W];
  logic [TGT_W-1:0]      tgt_q;
  logic [COUNT_BITS-1:0] cnt_q, vis_q;

  logic [ADDR_W-1:0]     clr_idx;
  logic [ROW_W-1:0]      row_r;
  logic                  chain_r;
  logic [IDX_W-1:0]      prev_state;
  logic [COL_W-1:0]      prev_choice, choice_r, best_col, t_cnt, c_cnt;
  logic [COUNT_BITS-1:0] d_r;
  logic [SCORE_W-1:0]    bound_r, best;
  logic                  found;

  germ_tag_t             iss;
  logic [COL_W-1:0]      iss_col;
  logic                  sc_valid, sc_elig;
  logic [SCORE_W-1:0]    sc_score;
  logic [COL_W-1:0]      sc_col;

  logic                  accept, is_step, step_ok, is_load, load_ok;
  logic [IDX_W-1:0]      step_row4;
  logic [ROW_W-1:0]      step_row;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  last_t, last_c, win, sc_last, proceed;
  logic [COUNT_BITS-1:0] d_new, cnt_new;

  // Input decode
  always_comb begin
    accept    = in_valid && !in_stall;
    is_step   = (command == CMD_STEP) || (command == CMD_CHAIN);
    step_row4 = (command == CMD_CHAIN) ? prev_state : row_index;
    step_row  = ROW_W'(step_row4);
    step_ok   = 32'(step_row4) < 32'(nr);
    is_load   = command == CMD_LOAD;
    load_ok   = (32'(row_index) < 32'(MAX_ROWS)) && (32'(column_index) < 32'(MAX_COLUMNS));
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    last_t  = {1'b0, t_cnt} == nc - 1'b1;
    last_c  = {1'b0, c_cnt} == nc - 1'b1;
    d_new   = (vis_q == CMAX) ? vis_q : vis_q + 1'b1;
    cnt_new = (cnt_q == CMAX) ? cnt_q : cnt_q + 1'b1;
    win     = sc_valid && sc_elig && (sc_score <= bound_r) && (!found || sc_score <= best);
    sc_last = sc_valid && ({1'b0, sc_col} == nc - 1'b1);
    proceed = !out_valid || !out_stall;
    rd_addr = (state == S_SCORE) ? {row_r, t_cnt} : {row_r, choice_r};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:   if (clr_idx == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept && command == CMD_CLEAR) state_next = S_CLR;
        else if (accept && is_step && step_ok) state_next = S_VIS;
      end
      S_VIS:   state_next = S_SCORE;
      S_SCORE: if (last_t && last_c) state_next = S_DRAIN;
      S_DRAIN: if (sc_last) state_next = S_CRD;
      S_CRD:   state_next = S_CWR;
      S_CWR:   if (proceed) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    iss.self  <= t_cnt == c_cnt;
    iss.first <= t_cnt == '0;
    iss.last  <= last_t;
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      prev_state  <= '0;
      prev_choice <= '0;
      out_valid   <= 1'b0;
      iss.valid   <= 1'b0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_idx <= clr_idx + 1'b1;
      if (state == S_IDLE && accept && command == CMD_CLEAR) clr_idx <= '0;
      if (state == S_IDLE && accept && command == CMD_START) prev_state <= row_index;
      iss.valid <= (state == S_SCORE);
      if (state == S_VIS) found <= 1'b0;
      else if (win) found <= 1'b1;
      if (state == S_CWR && proceed) begin
        out_valid   <= 1'b1;
        prev_choice <= choice_r;
        if (chain_r) prev_state <= IDX_W'(choice_r);
      end else if (!out_stall) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      row_r   <= step_row;
      chain_r <= command == CMD_CHAIN;
    end
    if (state == S_VIS) begin
      d_r     <= d_new;
      bound_r <= SCORE_W'({d_new, 17'b0});
      t_cnt   <= '0;
      c_cnt   <= '0;
    end
    if (state == S_SCORE) begin
      t_cnt <= last_t ? '0 : t_cnt + 1'b1;
      if (last_t) c_cnt <= c_cnt + 1'b1;
    end
    iss_col   <= c_cnt;
    if (win) begin
      best     <= sc_score;
      best_col <= sc_col;
    end
    if (state == S_DRAIN && sc_last) begin
      choice_r <= win ? sc_col : (found ? best_col : prev_choice);
    end
    if (state == S_CWR && proceed) begin
      chosen_column   <= IDX_W'(choice_r);
      row_used        <= IDX_W'(row_r);
      count_saturated <= (d_r == CMAX) || (cnt_new == CMAX);
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && is_load && load_ok) begin
      tgt_mem[{ROW_W'(row_index), COL_W'(column_index)}] <=
        (target_value > Q_ONE) ? Q_ONE : target_value;
    end
    if (state == S_CLR) begin
      cnt_mem[clr_idx] <= '0;
    end else if (state == S_CWR && proceed) begin
      cnt_mem[{row_r, choice_r}] <= cnt_new;
    end
    if (state == S_CLR) begin
      vis_mem[clr_idx[ROW_W-1:0]] <= '0;
    end else if (state == S_VIS) begin
      vis_mem[row_r] <= d_new;
    end
    tgt_q <= tgt_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    vis_q <= vis_mem[step_row];
  end

  germ_term_unit #(
    .COUNT_BITS(COUNT_BITS),
    .COL_W     (COL_W)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .tag     (iss),
    .col     (iss_col),
    .p       (tgt_q),
    .n       (cnt_q),
    .d       (d_r),
    .sc_valid(sc_valid),
    .sc_score(sc_score),
    .sc_elig (sc_elig),
    .sc_col  (sc_col)
  );

endmodule
`default_nettype wire

// ===== design/germ_checker.sv =====
// Port-level checker for the row matcher and its bind to the top level.
`default_nettype none
module germ_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [germ_pkg::CMD_W-1:0]  command,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [germ_pkg::IDX_W-1:0]  chosen_column,
  input wire logic [germ_pkg::IDX_W-1:0]  row_used
);
  import germ_pkg::*;

  // Reset starts the clearing sweep, so no word is taken right after it
  a_reset_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("word accepted right after reset");

  // A clear word starts a sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_CLEAR |=> in_stall)
    else $error("clear word did not start sweep");

  // A step's result does not appear right after the step is accepted
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_STEP |=> !$rose(out_valid))
    else $error("result appeared one cycle after step");

  // Held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_column) && $stable(row_used))
    else $error("stalled result changed");

endmodule

bind greedy_empirical_row_matcher germ_checker u_germ_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .command      (command),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chosen_column(chosen_column),
  .row_used     (row_used)
);
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the greedy empirical row matcher with a built-in score predictor.
`default_nettype none
module tb;
  import germ_pkg::*;

  localparam int          ROWS      = MAX_ROWS_DEF;
  localparam int          COLS      = MAX_COLUMNS_DEF;
  localparam int          COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
  localparam int          SETTLE    = 300;
  localparam longint      LIMIT     = 6000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd5;

  typedef struct {
    logic [IDX_W-1:0] chosen;
    logic [IDX_W-1:0] row;
    logic             sat;
  } trace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [IDX_W-1:0] row_index = '0;
  logic [IDX_W-1:0] column_index = '0;
  logic [TGT_W-1:0] target_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] chosen_column;
  logic [IDX_W-1:0] row_used;
  logic count_saturated;

  // Predictor state
  logic [TGT_W-1:0] tgt[ROWS][COLS];
  logic [15:0]      cell_cnt[ROWS][COLS];
  logic [15:0]      visits[ROWS];
  logic [IDX_W-1:0] prev_state, prev_choice;
  logic [CFG_W-1:0] rows_cfg, cols_cfg;

  trace_t trace_q[$];
  trace_t got;
  int     errors = 0;
  int     words_sent = 0;
  int     results_seen = 0;
  int     sat_seen = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  longint cycles = 0;

  greedy_empirical_row_matcher dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row_index(row_index), .column_index(column_index),
    .target_value(target_value), .out_valid(out_valid), .out_stall(out_stall),
    .chosen_column(chosen_column), .row_used(row_used),
    .count_saturated(count_saturated)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[greedy_empirical_row_matcher] ERROR");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (trace_q.size() == 0) begin
        $error("unexpected result: chosen_column %0d row_used %0d", chosen_column, row_used);
        errors++;
      end else begin
        got = trace_q.pop_front();
        results_seen++;
        if (count_saturated) sat_seen++;
        if (chosen_column !== got.chosen) begin
          $error("chosen_column: expected %0d, got %0d", got.chosen, chosen_column);
          errors++;
        end
        if (row_used !== got.row) begin
          $error("row_used: expected %0d, got %0d", got.row, row_used);
          errors++;
        end
        if (count_saturated !== got.sat) begin
          $error("count_saturated: expected %0d, got %0d", got.sat, count_saturated);
          errors++;
        end
      end
    end
  end

  function automatic int active_limit(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // One step of the greedy matcher; returns 1 when a result is produced
  function automatic bit score_row(input logic [IDX_W-1:0] r);
    int nr, nc;
    longint unsigned d, bound, best, score, n, a, b;
    bit found, sat;
    logic [IDX_W-1:0] choice;
    trace_t e;
    nr = active_limit(rows_cfg, ROWS);
    nc = active_limit(cols_cfg, COLS);
    if (r >= nr) return 0;
    if (visits[r] < COUNT_MAX) visits[r]++;
    d = visits[r];
    bound = 2 * d * 65536;
    best = 0;
    found = 0;
    choice = prev_choice;
    for (int c = 0; c < nc; c++) begin
      if (tgt[r][c] == 0) continue;
      score = 0;
      for (int t = 0; t < nc; t++) begin
        n = cell_cnt[r][t];
        if (t == c) n++;
        a = longint'(tgt[r][t]) * d;
        b = n * 65536;
        score += (a >= b) ? a - b : b - a;
      end
      if (score <= bound && (!found || score <= best)) begin
        best = score;
        choice = IDX_W'(c);
        found = 1;
      end
    end
    if (cell_cnt[r][choice] < COUNT_MAX) cell_cnt[r][choice]++;
    sat = (visits[r] == COUNT_MAX) || (cell_cnt[r][choice] == COUNT_MAX);
    prev_choice = choice;
    e.chosen = choice;
    e.row = r;
    e.sat = sat;
    trace_q.push_back(e);
    return 1;
  endfunction

  function automatic void predict_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                                       input logic [IDX_W-1:0] col, input logic [TGT_W-1:0] v);
    case (cmd)
      CMD_LOAD:  tgt[r][col] = (v > Q_ONE) ? Q_ONE : v;
      CMD_STEP:  void'(score_row(r));
      CMD_CHAIN: if (score_row(prev_state)) prev_state = prev_choice;
      CMD_START: prev_state = r;
      CMD_CLEAR: begin
        foreach (cell_cnt[i, j]) cell_cnt[i][j] = '0;
        foreach (visits[i]) visits[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // Send one word; entered and left at a falling edge
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] col, input logic [TGT_W-1:0] v);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    row_index = r;
    column_index = col;
    target_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(cmd, r, col, v);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drain outstanding results, then let any silent word finish
  task automatic settle();
    while (trace_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
    settle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    if (idx == REG_ROWS) rows_cfg = v;
    else cols_cfg = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [TGT_W-1:0] pick_target();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return '0;
    if (roll < 35) return Q_ONE;
    if (roll < 45) return TGT_W'($urandom_range(131071, 65537));
    return TGT_W'($urandom_range(65536, 1));
  endfunction

  // Random word, mostly steps on active rows
  task automatic random_word();
    int roll, nr;
    logic [IDX_W-1:0] r;
    roll = $urandom_range(99);
    nr = active_limit(rows_cfg, ROWS);
    r = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(nr - 1)) : IDX_W'($urandom);
    if (roll < 15)      send_word(CMD_LOAD, r, IDX_W'($urandom), pick_target());
    else if (roll < 55) send_word(CMD_STEP, r, IDX_W'($urandom), TGT_W'($urandom));
    else if (roll < 85) send_word(CMD_CHAIN, r, IDX_W'($urandom), TGT_W'($urandom));
    else if (roll < 92) send_word(CMD_START, r, IDX_W'($urandom), TGT_W'($urandom));
    else if (roll < 95) send_word(CMD_CLEAR, r, IDX_W'($urandom), TGT_W'($urandom));
    else send_word(CMD_LOAD + CMD_W'($urandom_range(7, 5)), r, IDX_W'($urandom),
                   TGT_W'($urandom));
  endtask

  // Every target is written before any step reads it
  task automatic test_fill_table();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        send_word(CMD_LOAD, IDX_W'(r), IDX_W'(c),
                  ($urandom_range(9) == 0) ? '0 : TGT_W'($urandom_range(65536, 1)));
  endtask

  // Field extremes, each command, and the corner behaviors
  task automatic test_directed();
    send_word(CMD_STEP, 0, 0, '0);
    send_word(CMD_STEP, 15, 15, '1);
    send_word(CMD_LOAD, 2, 3, '1);          // above one, clamps
    send_word(CMD_LOAD, 2, 0, Q_ONE);
    send_word(CMD_STEP, 2, 0, '0);
    send_word(CMD_START, 15, 0, '0);
    send_word(CMD_CHAIN, 0, 0, '0);
    send_word(CMD_CHAIN, 0, 0, '0);
    send_word(CMD_CLEAR, 0, 0, '0);
    send_word(CMD_UNUSED, 1, 1, '1);
    send_word(CMD_W'(CMD_UNUSED + 1), 1, 1, '1);
    send_word(CMD_W'(CMD_UNUSED + 2), 1, 1, '1);
    send_word(CMD_STEP, 1, 0, '0);
    // no eligible column: all targets of row 4 zero in the first two columns
    write_reg(REG_COLS, 5'd2);
    send_word(CMD_LOAD, 4, 0, '0);
    send_word(CMD_LOAD, 4, 1, '0);
    send_word(CMD_STEP, 4, 0, '0);
    send_word(CMD_STEP, 4, 0, '0);
    // inactive row gives nothing
    write_reg(REG_ROWS, 5'd3);
    send_word(CMD_STEP, 9, 0, '0);
    send_word(CMD_START, 12, 0, '0);
    send_word(CMD_CHAIN, 0, 0, '0);
    send_word(CMD_STEP, 2, 0, '0);
  endtask

  // Random words across register settings and idle mixes
  task automatic test_random_sweep();
    logic [CFG_W-1:0] rset[6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd9};
    logic [CFG_W-1:0] cset[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd7};
    int ipct[4] = '{0, 83, 0, 33};
    int spct[4] = '{0, 0, 83, 33};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ROWS, rset[p]);
      write_reg(REG_COLS, cset[p]);
      for (int m = 0; m < 4; m++) begin
        idle_pct = ipct[m];
        stall_pct = spct[m];
        for (int i = 0; i < 15; i++) random_word();
        if (m == 3) begin
          idle_pct = 0;
          stall_pct = 0;
          for (int i = 0; i < 10; i++) random_word();
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Long receiver hold-off while steps keep coming, so the block backs up
  task automatic test_backpressure();
    write_reg(REG_ROWS, 5'd16);
    write_reg(REG_COLS, 5'd2);
    hold_left = 2000;
    for (int i = 0; i < 30; i++) send_word(CMD_STEP, IDX_W'($urandom), 0, '0);
  endtask

  initial begin
    rows_cfg = CFG_RESET;
    cols_cfg = CFG_RESET;
    prev_state = '0;
    prev_choice = '0;
    foreach (cell_cnt[i, j]) cell_cnt[i][j] = '0;
    foreach (tgt[i, j]) tgt[i][j] = '0;
    foreach (visits[i]) visits[i] = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_fill_table();
    test_directed();
    test_random_sweep();
    test_backpressure();

    settle();
    $display("Sent %0d words, checked %0d results (%0d saturated).",
             words_sent, results_seen, sat_seen);
    $display("Covered loads, given and chained steps, start, clear, ignored codes, stalls.");
    if (errors == 0 && trace_q.size() == 0) begin
      $display("[greedy_empirical_row_matcher] OK");
    end else begin
      $display("[greedy_empirical_row_matcher] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
